// ----- rtl/core/phrgbd_pkg.sv -----
`timescale 1ns / 1ps

package phrgbd_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X,
    CFG_FOCAL_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_DEPTH_NEAR,
    CFG_DEPTH_FAR,
    CFG_DEPTH_SCALE
  } cfg_reg_t;

  // Reset values of the registers.
  localparam logic [18:0] FOCAL_X_RST     = 19'd128913;
  localparam logic [18:0] FOCAL_Y_RST     = 19'd128929;
  localparam logic [18:0] CENTER_X_RST    = 19'd83330;
  localparam logic [18:0] CENTER_Y_RST    = 19'd85052;
  localparam logic [22:0] DEPTH_NEAR_RST  = 23'd32768;
  localparam logic [22:0] DEPTH_FAR_RST   = 23'd252969;
  localparam logic [23:0] DEPTH_SCALE_RST = 24'd4973714;

  // Depth of 1.0 m in Q7.16, used in place of a zero depth.
  localparam logic signed [23:0] UNIT_DEPTH = 24'sd65536;

  // Largest depth code.
  localparam logic [7:0] DEPTH_CODE_MAX = 8'hFF;

  // One input point.
  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [7:0]         color_blue;
    logic [7:0]         color_green;
    logic [7:0]         color_red;
  } in_beat_t;

  // One projected pixel.
  typedef struct packed {
    logic [9:0] pixel_column;
    logic [8:0] pixel_row;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] depth_code;
    logic       depth_write;
  } out_beat_t;

  // Per-item flags and pass-through fields that ride along the divider.
  typedef struct packed {
    logic        neg_c;
    logic        neg_r;
    logic        zok_c;
    logic        zok_r;
    logic        ovf_c;
    logic        ovf_r;
    logic [7:0]  code;
    logic        dwr;
    logic [23:0] color;
  } side_t;

endpackage

// ----- rtl/core/pinhole_point_to_rgbd_pixel_unit.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  phrgbd_pkg::in_beat_t (point and color)
// out_     output     out_valid/out_stall  phrgbd_pkg::out_beat_t (pixel, color, depth)
// cfg_     input      cfg_we               cfg_index, cfg_wdata (no read-back)
//
// One point enters per cycle while in_stall is low; Q = clog2(max(width, height)).
// The Q-stage restoring divider, one quotient bit per stage,
// divides by the depth; both coordinates share the divisor and divide in parallel.
// Reset (synchronous, rst_n low) loads the register defaults and empties every stage.
// Each stage moves on when the stage after it is empty or moving, so bubbles close up
// and a stalled output holds its beat; points off the image leave with no output beat.
module pinhole_point_to_rgbd_pixel_unit #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  phrgbd_pkg::in_beat_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output phrgbd_pkg::out_beat_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [phrgbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phrgbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int MAXDIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QD     = $clog2(MAXDIM);
  localparam int NST    = 5 + QD;
  localparam int PW     = 44;
  localparam int SW     = 45;
  localparam int MW     = 44;
  localparam int DW     = 32;
  localparam int NW     = 46;
  localparam int D2W    = DW + 1;
  localparam int TW     = ((NW > D2W + QD) ? NW : D2W + QD) + 1;

  // Configuration registers.
  logic [18:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [22:0] depth_near_r, depth_far_r;
  logic [23:0] depth_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r     <= phrgbd_pkg::FOCAL_X_RST;
      focal_y_r     <= phrgbd_pkg::FOCAL_Y_RST;
      center_x_r    <= phrgbd_pkg::CENTER_X_RST;
      center_y_r    <= phrgbd_pkg::CENTER_Y_RST;
      depth_near_r  <= phrgbd_pkg::DEPTH_NEAR_RST;
      depth_far_r   <= phrgbd_pkg::DEPTH_FAR_RST;
      depth_scale_r <= phrgbd_pkg::DEPTH_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        phrgbd_pkg::CFG_FOCAL_X:     focal_x_r     <= cfg_wdata[18:0];
        phrgbd_pkg::CFG_FOCAL_Y:     focal_y_r     <= cfg_wdata[18:0];
        phrgbd_pkg::CFG_CENTER_X:    center_x_r    <= cfg_wdata[18:0];
        phrgbd_pkg::CFG_CENTER_Y:    center_y_r    <= cfg_wdata[18:0];
        phrgbd_pkg::CFG_DEPTH_NEAR:  depth_near_r  <= cfg_wdata[22:0];
        phrgbd_pkg::CFG_DEPTH_FAR:   depth_far_r   <= cfg_wdata[22:0];
        phrgbd_pkg::CFG_DEPTH_SCALE: depth_scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic [NST:0]   en;
  logic [NST-1:0] vld_r, vld_nxt;
  logic           out_valid_r, out_valid_nxt;
  phrgbd_pkg::out_beat_t out_data_r, out_data_nxt;

  always_comb begin
    en[NST] = !out_valid_r || !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NST; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: effective depth, the four products and the depth window test.
  logic signed [23:0] zeff_nxt, zeff_s1_r;
  logic signed [PW-1:0] pxc_nxt, pcx_nxt, pyr_nxt, pcy_nxt;
  logic signed [PW-1:0] pxc_s1_r, pcx_s1_r, pyr_s1_r, pcy_s1_r;
  logic [22:0] dz_nxt, dz_s1_r;
  logic        dwr_nxt, dwr_s1_r, zneg_s1_r;
  logic [23:0] color_s1_r;

  always_comb begin
    zeff_nxt = (in_data.point_z == '0) ? phrgbd_pkg::UNIT_DEPTH : in_data.point_z;
    pxc_nxt  = $signed({1'b0, focal_x_r}) * in_data.point_x;
    pcx_nxt  = $signed({1'b0, center_x_r}) * zeff_nxt;
    pyr_nxt  = $signed({1'b0, focal_y_r}) * in_data.point_y;
    pcy_nxt  = $signed({1'b0, center_y_r}) * zeff_nxt;
    dz_nxt   = in_data.point_z[22:0] - depth_near_r;
    dwr_nxt  = (in_data.point_z > $signed({1'b0, depth_near_r})) &&
               (in_data.point_z < $signed({1'b0, depth_far_r}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zeff_s1_r  <= zeff_nxt;
      zneg_s1_r  <= in_data.point_z[23];
      pxc_s1_r   <= pxc_nxt;
      pcx_s1_r   <= pcx_nxt;
      pyr_s1_r   <= pyr_nxt;
      pcy_s1_r   <= pcy_nxt;
      dz_s1_r    <= dz_nxt;
      dwr_s1_r   <= dwr_nxt;
      color_s1_r <= {in_data.color_blue, in_data.color_green, in_data.color_red};
    end
  end

  // Stage 2: numerators, depth magnitude and the depth-code product.
  logic signed [SW-1:0] sumc_s2_r, sumr_s2_r;
  logic [23:0] azeff_nxt, azeff_s2_r;
  logic [46:0] prod_s2_r;
  logic        zneg_s2_r, dwr_s2_r;
  logic [23:0] color_s2_r;

  assign azeff_nxt = zneg_s1_r ? (24'd0 - 24'(zeff_s1_r)) : 24'(zeff_s1_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sumc_s2_r  <= SW'(pxc_s1_r) + SW'(pcx_s1_r);
      sumr_s2_r  <= SW'(pyr_s1_r) + SW'(pcy_s1_r);
      azeff_s2_r <= azeff_nxt;
      prod_s2_r  <= 47'(dz_s1_r) * 47'(depth_scale_r);
      zneg_s2_r  <= zneg_s1_r;
      dwr_s2_r   <= dwr_s1_r;
      color_s2_r <= color_s1_r;
    end
  end

  // Stage 3: sign and magnitude of each quotient, divisor, rounded depth code.
  logic [MW-1:0] magc_nxt, magr_nxt, magc_s3_r, magr_s3_r;
  logic          negc_s3_r, negr_s3_r, dwr_s3_r;
  logic [DW-1:0] den_s3_r;
  logic [16:0]   rnd;
  logic [7:0]    code_nxt, code_s3_r;
  logic [23:0]   color_s3_r;

  always_comb begin
    magc_nxt = sumc_s2_r[SW-1] ? MW'(-sumc_s2_r) : MW'(sumc_s2_r);
    magr_nxt = sumr_s2_r[SW-1] ? MW'(-sumr_s2_r) : MW'(sumr_s2_r);
    rnd      = {1'b0, prod_s2_r[46:31]} + 17'd1;
    if (!dwr_s2_r) begin
      code_nxt = '0;
    end else if (rnd[16:1] > 16'(phrgbd_pkg::DEPTH_CODE_MAX)) begin
      code_nxt = phrgbd_pkg::DEPTH_CODE_MAX;
    end else begin
      code_nxt = rnd[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      magc_s3_r  <= magc_nxt;
      magr_s3_r  <= magr_nxt;
      negc_s3_r  <= sumc_s2_r[SW-1] ^ zneg_s2_r;
      negr_s3_r  <= sumr_s2_r[SW-1] ^ zneg_s2_r;
      den_s3_r   <= {azeff_s2_r, 8'd0};
      code_s3_r  <= code_nxt;
      dwr_s3_r   <= dwr_s2_r;
      color_s3_r <= color_s2_r;
    end
  end

  // Stage 4: rounding dividends, and the zero test for negative quotients.
  logic [NW-1:0]  nc_s4_r, nr_s4_r;
  logic [D2W-1:0] d2_s4_r;
  phrgbd_pkg::side_t side_s4_nxt, side_s4_r;

  always_comb begin
    side_s4_nxt       = '0;
    side_s4_nxt.neg_c = negc_s3_r;
    side_s4_nxt.neg_r = negr_s3_r;
    side_s4_nxt.zok_c = {magc_s3_r, 1'b0} < (MW+1)'(den_s3_r);
    side_s4_nxt.zok_r = {magr_s3_r, 1'b0} < (MW+1)'(den_s3_r);
    side_s4_nxt.code  = code_s3_r;
    side_s4_nxt.dwr   = dwr_s3_r;
    side_s4_nxt.color = color_s3_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nc_s4_r   <= NW'({magc_s3_r, 1'b0}) + NW'(den_s3_r);
      nr_s4_r   <= NW'({magr_s3_r, 1'b0}) + NW'(den_s3_r);
      d2_s4_r   <= {den_s3_r, 1'b0};
      side_s4_r <= side_s4_nxt;
    end
  end

  // Stage 5: a quotient that needs more than Q bits is off the image.
  logic [NW-1:0]  nc_s5_r, nr_s5_r;
  logic [D2W-1:0] d2_s5_r;
  phrgbd_pkg::side_t side_s5_nxt, side_s5_r;

  always_comb begin
    side_s5_nxt       = side_s4_r;
    side_s5_nxt.ovf_c = TW'(nc_s4_r) >= (TW'(d2_s4_r) << QD);
    side_s5_nxt.ovf_r = TW'(nr_s4_r) >= (TW'(d2_s4_r) << QD);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nc_s5_r   <= nc_s4_r;
      nr_s5_r   <= nr_s4_r;
      d2_s5_r   <= d2_s4_r;
      side_s5_r <= side_s5_nxt;
    end
  end

  // Divider stages: each one settles one quotient bit, most significant first.
  logic [NW-1:0]  rc_r [QD];
  logic [NW-1:0]  rr_r [QD];
  logic [QD-1:0]  qc_r [QD];
  logic [QD-1:0]  qr_r [QD];
  logic [D2W-1:0] dd_r [QD];
  phrgbd_pkg::side_t sd_r [QD];

  logic [NW-1:0]  rc_src [QD];
  logic [NW-1:0]  rr_src [QD];
  logic [QD-1:0]  qc_src [QD];
  logic [QD-1:0]  qr_src [QD];
  logic [D2W-1:0] dd_src [QD];
  phrgbd_pkg::side_t sd_src [QD];

  logic [TW-1:0]  tc [QD];
  logic [TW-1:0]  tr [QD];
  logic [NW-1:0]  rc_nxt [QD];
  logic [NW-1:0]  rr_nxt [QD];
  logic [QD-1:0]  qc_nxt [QD];
  logic [QD-1:0]  qr_nxt [QD];

  always_comb begin
    rc_src[0] = nc_s5_r;
    rr_src[0] = nr_s5_r;
    qc_src[0] = '0;
    qr_src[0] = '0;
    dd_src[0] = d2_s5_r;
    sd_src[0] = side_s5_r;
    for (int i = 1; i < QD; i++) begin
      rc_src[i] = rc_r[i-1];
      rr_src[i] = rr_r[i-1];
      qc_src[i] = qc_r[i-1];
      qr_src[i] = qr_r[i-1];
      dd_src[i] = dd_r[i-1];
      sd_src[i] = sd_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      tc[i]     = TW'(rc_src[i]) - (TW'(dd_src[i]) << (QD - 1 - i));
      tr[i]     = TW'(rr_src[i]) - (TW'(dd_src[i]) << (QD - 1 - i));
      rc_nxt[i] = tc[i][TW-1] ? rc_src[i] : NW'(tc[i]);
      rr_nxt[i] = tr[i][TW-1] ? rr_src[i] : NW'(tr[i]);
      qc_nxt[i] = qc_src[i] | (QD'(!tc[i][TW-1]) << (QD - 1 - i));
      qr_nxt[i] = qr_src[i] | (QD'(!tr[i][TW-1]) << (QD - 1 - i));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      if (en[5+i]) begin
        rc_r[i] <= rc_nxt[i];
        rr_r[i] <= rr_nxt[i];
        qc_r[i] <= qc_nxt[i];
        qr_r[i] <= qr_nxt[i];
        dd_r[i] <= dd_src[i];
        sd_r[i] <= sd_src[i];
      end
    end
  end

  // Output register: range check and final pixel selection.
  phrgbd_pkg::side_t sd_last;
  logic [QD-1:0]     qc_last, qr_last;
  logic              col_ok, row_ok;

  always_comb begin
    sd_last = sd_r[QD-1];
    qc_last = qc_r[QD-1];
    qr_last = qr_r[QD-1];
    col_ok  = sd_last.neg_c ? sd_last.zok_c :
              (!sd_last.ovf_c && ({1'b0, qc_last} < (QD+1)'(IMAGE_WIDTH)));
    row_ok  = sd_last.neg_r ? sd_last.zok_r :
              (!sd_last.ovf_r && ({1'b0, qr_last} < (QD+1)'(IMAGE_HEIGHT)));

    out_data_nxt.pixel_column = sd_last.neg_c ? '0 : 10'(qc_last);
    out_data_nxt.pixel_row    = sd_last.neg_r ? '0 : 9'(qr_last);
    out_data_nxt.out_blue     = sd_last.color[23:16];
    out_data_nxt.out_green    = sd_last.color[15:8];
    out_data_nxt.out_red      = sd_last.color[7:0];
    out_data_nxt.depth_code   = sd_last.code;
    out_data_nxt.depth_write  = sd_last.dwr;

    out_valid_nxt = en[NST] ? (vld_r[NST-1] && col_ok && row_ok) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A depth code only leaves the block when it is marked for writing.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.depth_write |-> out_data_r.depth_code == '0)
    else $error("depth code set without depth write");

  // Every delivered pixel lies on the image.
  a_on_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({3'b0, out_data_r.pixel_column} < 13'(IMAGE_WIDTH)) &&
                    ({4'b0, out_data_r.pixel_row} < 13'(IMAGE_HEIGHT)))
    else $error("pixel off the image");

  // A blocked last divider stage keeps its item.
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] && !en[NST-1] |=> vld_r[NST-1])
    else $error("last divider stage lost an item");

endmodule
